// ===== rtl/sts_pkg.sv =====
// Shared types, constants and arithmetic helpers for the segment tree block.
// Used by sts_node_store and segment_tree_sum_max; depends on nothing else.
package sts_pkg;

  localparam int CAPACITY   = 1024;               // positions the tree can hold
  localparam int NODE_COUNT = 4 * CAPACITY;       // node numbers stay below this
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int POS_W      = 11;                 // position and size fields
  localparam int IN_VAL_W   = 16;                 // input value
  localparam int VAL_W      = 48;                 // node sums, maxima, answers

  localparam logic signed [VAL_W-1:0] MAX_VAL = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [NODE_AW-1:0] NODE_ROOT = NODE_AW'(1);
  localparam logic [NODE_AW-1:0] NODE_LAST = NODE_AW'(NODE_COUNT - 1);

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SET,
    MODE_SUM,
    MODE_MAX
  } mode_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sum;
    logic signed [VAL_W-1:0] maxv;
  } node_t;

  typedef struct packed {
    logic               en;
    logic [NODE_AW-1:0] addr;
    node_t              data;
  } wr_req_t;

  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? MIN_VAL : MAX_VAL;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] max_of(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // One accumulation step of a query: saturating sum or running maximum.
  function automatic logic signed [VAL_W-1:0] acc_step(input logic is_max,
                                                       input logic signed [VAL_W-1:0] acc,
                                                       input logic signed [VAL_W-1:0] x);
    return is_max ? max_of(acc, x) : sat_add(acc, x);
  endfunction

endpackage

// ===== rtl/sts_node_store.sv =====
// Node store of the segment tree: one write port, one registered read port.
// Runs a zeroing sweep over every node after reset and on request.
// Depends on sts_pkg.
module sts_node_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr_start,
  output logic                          clr_busy,
  input  sts_pkg::wr_req_t              wr,
  input  logic [sts_pkg::NODE_AW-1:0]   rd_addr,
  output sts_pkg::node_t                rd_data
);
  import sts_pkg::*;

  node_t              node_mem [NODE_COUNT];
  node_t              rd_data_r;
  logic               busy_r;
  logic [NODE_AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (clr_start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + NODE_AW'(1);
      if (cnt_r == NODE_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // the sweep owns the write port while it runs
  always_ff @(posedge clk) begin
    if (busy_r) begin
      node_mem[cnt_r] <= '0;
    end else if (wr.en) begin
      node_mem[wr.addr] <= wr.data;
    end
    rd_data_r <= node_mem[rd_addr];
  end

  assign clr_busy = busy_r;
  assign rd_data  = rd_data_r;

endmodule

// ===== rtl/segment_tree_sum_max.sv =====
// Segment tree over signed values at positions 1..size_in_use with add, set, range sum and
// range maximum. Every node is visited through the single read port of the node store, one
// node per cycle. An add or set walks down to the leaf, then reads, updates and writes back
// one node per level on the way up. A query finds the node where the range splits, walks both
// boundary paths down together, then climbs the left and then the right path reading the
// covering nodes; its answer may wait on out_ready. A range that one node covers skips the
// boundary walks, and a query with bad bounds goes straight to its answer. After reset and
// after every write of size_in_use the store is zeroed in a pass over all 4096 nodes, during
// which no transaction is taken.
// Depends on sts_pkg and sts_node_store.
module segment_tree_sum_max (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [sts_pkg::POS_W-1:0]            cfg_size_in_use,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic [sts_pkg::POS_W-1:0]            in_left_index,
  input  logic [sts_pkg::POS_W-1:0]            in_right_index,
  input  logic signed [sts_pkg::IN_VAL_W-1:0]  in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sts_pkg::VAL_W-1:0]     out_answer,
  output logic                                 out_bad_range
);
  import sts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UDESC,
    S_ULEAF,
    S_UUP,
    S_QSPLIT,
    S_QDESC,
    S_QL,
    S_QR,
    S_QFIN,
    S_QONE,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [POS_W-1:0]        l_r, l_nxt;
  logic [POS_W-1:0]        r_r, r_nxt;
  logic signed [IN_VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]        size_r, size_nxt;

  logic [NODE_AW-1:0]      node_a_r, node_a_nxt, node_b_r, node_b_nxt;
  logic [POS_W-1:0]        lo_a_r, lo_a_nxt, hi_a_r, hi_a_nxt;
  logic [POS_W-1:0]        lo_b_r, lo_b_nxt, hi_b_r, hi_b_nxt;
  logic [NODE_AW-1:0]      split_r, split_nxt;
  node_t                   cur_r, cur_nxt;
  logic signed [VAL_W-1:0] acc_l_r, acc_l_nxt, acc_rt_r, acc_rt_nxt;
  logic                    pend_r, pend_nxt;
  logic signed [VAL_W-1:0] res_r, res_nxt;
  logic                    res_bad_r, res_bad_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_answer_r, out_answer_nxt;
  logic                    out_bad_r, out_bad_nxt;

  logic                    clr_busy;
  wr_req_t                 mem_wr;
  logic [NODE_AW-1:0]      rd_addr;
  node_t                   rd_data;

  logic [POS_W-1:0]        mid_a, mid_b;
  logic [NODE_AW-1:0]      lchild_a, rchild_a, parent_a, lchild_b, rchild_b, parent_b;
  logic                    is_max, in_acc, done_a, done_b;
  logic signed [VAL_W-1:0] ext_val, new_val, rd_val, acc_init, acc_in_l, acc_in_r;

  sts_node_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (cfg_wr_en),
    .clr_busy  (clr_busy),
    .wr        (mem_wr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign in_ready = (state_r == S_IDLE) && !clr_busy;
  assign in_acc   = in_valid && in_ready;

  assign mid_a    = lo_a_r + ((hi_a_r - lo_a_r) >> 1);
  assign mid_b    = lo_b_r + ((hi_b_r - lo_b_r) >> 1);
  assign lchild_a = {node_a_r[NODE_AW-2:0], 1'b0};
  assign rchild_a = {node_a_r[NODE_AW-2:0], 1'b1};
  assign parent_a = {1'b0, node_a_r[NODE_AW-1:1]};
  assign lchild_b = {node_b_r[NODE_AW-2:0], 1'b0};
  assign rchild_b = {node_b_r[NODE_AW-2:0], 1'b1};
  assign parent_b = {1'b0, node_b_r[NODE_AW-1:1]};

  assign is_max   = (mode_r == MODE_MAX);
  assign ext_val  = {{(VAL_W-IN_VAL_W){val_r[IN_VAL_W-1]}}, val_r};
  assign new_val  = (mode_r == MODE_SET) ? ext_val : sat_add(rd_data.sum, ext_val);
  assign rd_val   = is_max ? rd_data.maxv : rd_data.sum;
  assign acc_init = is_max ? MIN_VAL : '0;
  assign acc_in_l = pend_r ? acc_step(is_max, acc_l_r, rd_val) : acc_l_r;
  assign acc_in_r = pend_r ? acc_step(is_max, acc_rt_r, rd_val) : acc_rt_r;

  // suffix walk stops once the left bound is at or below the node's low end;
  // prefix walk once the right bound covers the node's high end
  assign done_a   = (l_r <= lo_a_r);
  assign done_b   = (hi_b_r <= r_r);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    val_nxt        = val_r;
    size_nxt       = size_r;
    node_a_nxt     = node_a_r;
    lo_a_nxt       = lo_a_r;
    hi_a_nxt       = hi_a_r;
    node_b_nxt     = node_b_r;
    lo_b_nxt       = lo_b_r;
    hi_b_nxt       = hi_b_r;
    split_nxt      = split_r;
    cur_nxt        = cur_r;
    acc_l_nxt      = acc_l_r;
    acc_rt_nxt     = acc_rt_r;
    pend_nxt       = 1'b0;
    res_nxt        = res_r;
    res_bad_nxt    = res_bad_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_answer_nxt = out_answer_r;
    out_bad_nxt    = out_bad_r;
    mem_wr         = '0;
    rd_addr        = node_a_r;

    if (cfg_wr_en) begin
      if (cfg_size_in_use == '0) begin
        size_nxt = POS_W'(1);
      end else if (cfg_size_in_use > POS_W'(CAPACITY)) begin
        size_nxt = POS_W'(CAPACITY);
      end else begin
        size_nxt = cfg_size_in_use;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = mode_t'(in_mode);
          l_nxt      = in_left_index;
          r_nxt      = in_right_index;
          val_nxt    = in_value;
          node_a_nxt = NODE_ROOT;
          lo_a_nxt   = POS_W'(1);
          hi_a_nxt   = size_r;
          if (mode_t'(in_mode) == MODE_ADD || mode_t'(in_mode) == MODE_SET) begin
            // an update outside 1..size is dropped
            if (in_left_index != '0 && in_left_index <= size_r) begin
              state_nxt = S_UDESC;
            end
          end else if (in_left_index == '0 || in_right_index > size_r ||
                       in_left_index > in_right_index) begin
            res_nxt     = '0;
            res_bad_nxt = 1'b1;
            state_nxt   = S_EMIT;
          end else begin
            state_nxt = S_QSPLIT;
          end
        end
      end

      S_UDESC: begin
        if (lo_a_r == hi_a_r) begin
          state_nxt = S_ULEAF;
        end else if (l_r <= mid_a) begin
          node_a_nxt = lchild_a;
          hi_a_nxt   = mid_a;
        end else begin
          node_a_nxt = rchild_a;
          lo_a_nxt   = mid_a + POS_W'(1);
        end
      end

      S_ULEAF: begin
        mem_wr.en        = 1'b1;
        mem_wr.addr      = node_a_r;
        mem_wr.data.sum  = new_val;
        mem_wr.data.maxv = new_val;
        cur_nxt.sum      = new_val;
        cur_nxt.maxv     = new_val;
        rd_addr          = {node_a_r[NODE_AW-1:1], ~node_a_r[0]};
        state_nxt        = (node_a_r == NODE_ROOT) ? S_IDLE : S_UUP;
      end

      S_UUP: begin
        // rd_data holds the sibling of node_a
        mem_wr.en        = 1'b1;
        mem_wr.addr      = parent_a;
        mem_wr.data.sum  = sat_add(cur_r.sum, rd_data.sum);
        mem_wr.data.maxv = max_of(cur_r.maxv, rd_data.maxv);
        cur_nxt          = mem_wr.data;
        node_a_nxt       = parent_a;
        rd_addr          = {parent_a[NODE_AW-1:1], ~parent_a[0]};
        if (parent_a == NODE_ROOT) begin
          state_nxt = S_IDLE;
        end
      end

      S_QSPLIT: begin
        if (l_r <= lo_a_r && hi_a_r <= r_r) begin
          state_nxt = S_QONE;
        end else if (r_r <= mid_a) begin
          node_a_nxt = lchild_a;
          hi_a_nxt   = mid_a;
        end else if (l_r > mid_a) begin
          node_a_nxt = rchild_a;
          lo_a_nxt   = mid_a + POS_W'(1);
        end else begin
          split_nxt  = node_a_r;
          node_a_nxt = lchild_a;
          hi_a_nxt   = mid_a;
          node_b_nxt = rchild_a;
          lo_b_nxt   = mid_a + POS_W'(1);
          hi_b_nxt   = hi_a_r;
          state_nxt  = S_QDESC;
        end
      end

      S_QDESC: begin
        if (done_a && done_b) begin
          pend_nxt  = 1'b1;
          acc_l_nxt = acc_init;
          state_nxt = S_QL;
        end else begin
          if (!done_a) begin
            if (l_r <= mid_a) begin
              node_a_nxt = lchild_a;
              hi_a_nxt   = mid_a;
            end else begin
              node_a_nxt = rchild_a;
              lo_a_nxt   = mid_a + POS_W'(1);
            end
          end
          if (!done_b) begin
            if (r_r > mid_b) begin
              node_b_nxt = rchild_b;
              lo_b_nxt   = mid_b + POS_W'(1);
            end else begin
              node_b_nxt = lchild_b;
              hi_b_nxt   = mid_b;
            end
          end
        end
      end

      // Climb the left path, deepest term first; a left child on the path
      // brings in its right sibling, which lies fully inside the range.
      S_QL: begin
        acc_l_nxt = acc_in_l;
        if (parent_a == split_r) begin
          rd_addr    = node_b_r;
          pend_nxt   = 1'b1;
          acc_rt_nxt = acc_init;
          state_nxt  = S_QR;
        end else begin
          rd_addr    = {node_a_r[NODE_AW-1:1], 1'b1};
          pend_nxt   = !node_a_r[0];
          node_a_nxt = parent_a;
        end
      end

      // mirror image: a right child brings in its left sibling
      S_QR: begin
        acc_rt_nxt = acc_in_r;
        if (parent_b == split_r) begin
          state_nxt = S_QFIN;
        end else begin
          rd_addr    = {node_b_r[NODE_AW-1:1], 1'b0};
          pend_nxt   = node_b_r[0];
          node_b_nxt = parent_b;
        end
      end

      S_QFIN: begin
        res_nxt     = is_max ? max_of(acc_l_r, acc_rt_r) : sat_add(acc_l_r, acc_rt_r);
        res_bad_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end

      S_QONE: begin
        res_nxt     = rd_val;
        res_bad_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = res_r;
          out_bad_nxt    = res_bad_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= POS_W'(CAPACITY);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    mode_r       <= mode_nxt;
    l_r          <= l_nxt;
    r_r          <= r_nxt;
    val_r        <= val_nxt;
    node_a_r     <= node_a_nxt;
    lo_a_r       <= lo_a_nxt;
    hi_a_r       <= hi_a_nxt;
    node_b_r     <= node_b_nxt;
    lo_b_r       <= lo_b_nxt;
    hi_b_r       <= hi_b_nxt;
    split_r      <= split_nxt;
    cur_r        <= cur_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_rt_r     <= acc_rt_nxt;
    res_r        <= res_nxt;
    res_bad_r    <= res_bad_nxt;
    out_answer_r <= out_answer_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_answer    = out_answer_r;
  assign out_bad_range = out_bad_r;

`ifndef SYNTHESIS
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> !clr_busy)
    else $error("node write issued during clearing pass");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> clr_busy)
    else $error("size write did not start a clearing pass");

  a_update_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UDESC) |-> (lo_a_r <= l_r) && (l_r <= hi_a_r))
    else $error("update walk left the target position");

  a_left_climb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QL) |-> (node_a_r[NODE_AW-1:1] != '0))
    else $error("left climb passed the split node");
`endif

endmodule

// ===== tb/segment_tree_sum_max_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for segment_tree_sum_max: point add/set, range sum and max
// queries and size changes, checked against a segment tree model kept in the bench.
// Depends on sts_pkg and the segment_tree_sum_max RTL.
module segment_tree_sum_max_tb;
  import sts_pkg::*;

  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 100;  // an update may still be in flight after the last answer

  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic signed [IN_VAL_W-1:0] in_val_t;

  localparam in_val_t VALUE_TOP    = 16'sh7FFF;
  localparam in_val_t VALUE_BOTTOM = 16'sh8000;

  typedef struct packed {
    val_t answer;
    logic bad_range;
  } query_result_t;

  logic    clk             = 1'b0;
  logic    rst_n           = 1'b0;
  logic    cfg_wr_en       = 1'b0;
  pos_t    cfg_size_in_use = '0;
  logic    in_valid        = 1'b0;
  logic    in_ready;
  logic [1:0] in_mode      = '0;
  pos_t    in_left_index   = '0;
  pos_t    in_right_index  = '0;
  in_val_t in_value        = '0;
  logic    out_valid;
  logic    out_ready       = 1'b0;
  val_t    out_answer;
  logic    out_bad_range;

  // shadow of the tree held by the block
  val_t          tree_sum [NODE_COUNT];
  val_t          tree_max [NODE_COUNT];
  int unsigned   tree_size = CAPACITY;
  query_result_t pending_answers [$];

  int errors          = 0;
  int ops_sent        = 0;
  int answers_checked = 0;
  int size_writes     = 0;
  bit steady          = 1'b0;  // no idling on either side while set

  segment_tree_sum_max dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_size_in_use(cfg_size_in_use),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_answer     (out_answer),
    .out_bad_range  (out_bad_range)
  );

  always #5 clk = ~clk;

  function automatic val_t clip_sum(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = a + b;
    if (s > MAX_VAL) return MAX_VAL;
    if (s < MIN_VAL) return MIN_VAL;
    return s[VAL_W-1:0];
  endfunction

  function automatic void clear_tree();
    for (int k = 0; k < NODE_COUNT; k++) begin
      tree_sum[k] = '0;
      tree_max[k] = '0;
    end
  endfunction

  function automatic void point_update(input int unsigned pos, input val_t val,
                                       input bit is_set);
    int unsigned path [32];
    int unsigned depth, node, lo, hi, mid, c;
    depth = 0;
    node  = 1;
    lo    = 1;
    hi    = tree_size;
    while (lo != hi && node < NODE_COUNT) begin
      path[depth] = node;
      depth++;
      mid = lo + (hi - lo) / 2;
      if (pos <= mid) begin
        node = 2 * node;
        hi   = mid;
      end else begin
        node = 2 * node + 1;
        lo   = mid + 1;
      end
    end
    if (node < NODE_COUNT) begin
      tree_sum[node] = is_set ? val : clip_sum(tree_sum[node], val);
      tree_max[node] = tree_sum[node];
    end
    // refresh the ancestors bottom-up
    while (depth > 0) begin
      depth--;
      node = path[depth];
      c    = 2 * node;
      if (c + 1 < NODE_COUNT) begin
        tree_sum[node] = clip_sum(tree_sum[c], tree_sum[c+1]);
        tree_max[node] = (tree_max[c] > tree_max[c+1]) ? tree_max[c] : tree_max[c+1];
      end
    end
  endfunction

  // Visits covering nodes left to right with an explicit stack.
  function automatic val_t range_query(input int unsigned l, input int unsigned r,
                                       input bit want_max);
    int unsigned st_node [64];
    int unsigned st_lo [64];
    int unsigned st_hi [64];
    int          sp;
    int unsigned node, lo, hi, mid;
    val_t        acc;
    acc        = want_max ? MIN_VAL : '0;
    sp         = 1;
    st_node[0] = 1;
    st_lo[0]   = 1;
    st_hi[0]   = tree_size;
    while (sp > 0) begin
      sp--;
      node = st_node[sp];
      lo   = st_lo[sp];
      hi   = st_hi[sp];
      if (node >= NODE_COUNT) continue;
      if (l <= lo && hi <= r) begin
        if (want_max) acc = (tree_max[node] > acc) ? tree_max[node] : acc;
        else          acc = clip_sum(acc, tree_sum[node]);
      end else begin
        mid = lo + (hi - lo) / 2;
        if (mid < r) begin
          st_node[sp] = 2 * node + 1;
          st_lo[sp]   = mid + 1;
          st_hi[sp]   = hi;
          sp++;
        end
        if (l <= mid) begin
          st_node[sp] = 2 * node;
          st_lo[sp]   = lo;
          st_hi[sp]   = mid;
          sp++;
        end
      end
    end
    return acc;
  endfunction

  function automatic void predict_op(input mode_t m, input pos_t l, input pos_t r,
                                     input in_val_t v);
    query_result_t res;
    if (m == MODE_ADD || m == MODE_SET) begin
      if (l >= 1 && l <= tree_size) point_update(l, val_t'(v), m == MODE_SET);
      return;
    end
    res.bad_range = (l == 0 || r > tree_size || l > r);
    res.answer    = res.bad_range ? '0 : range_query(l, r, m == MODE_MAX);
    pending_answers.push_back(res);
  endfunction

  task automatic send_op(input mode_t m, input pos_t l, input pos_t r, input in_val_t v);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_left_index  <= l;
    in_right_index <= r;
    in_value       <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_op(m, l, r, v);
    ops_sent++;
  endtask

  // Hold off the sender until every answer is back and the block has gone quiet.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input pos_t s);
    wait_quiet();
    cfg_wr_en       <= 1'b1;
    cfg_size_in_use <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tree_size = (s == 0) ? 1 : ((s > CAPACITY) ? CAPACITY : s);
    clear_tree();
    size_writes++;
  endtask

  task automatic send_random_op();
    mode_t   m;
    pos_t    l, r, t;
    in_val_t v;
    int      roll;
    roll = $urandom_range(99);
    m = (roll < 30) ? MODE_ADD : (roll < 50) ? MODE_SET : (roll < 75) ? MODE_SUM : MODE_MAX;
    v = in_val_t'($urandom);
    if ($urandom_range(99) < 12) begin
      // noise: any index pair, mostly out of range or reversed
      l = pos_t'($urandom_range(2047));
      r = pos_t'($urandom_range(2047));
    end else begin
      l = pos_t'($urandom_range(tree_size, 1));
      r = pos_t'($urandom_range(tree_size, 1));
      if (l > r) begin
        t = l;
        l = r;
        r = t;
      end
    end
    send_op(m, l, r, v);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_op();
  endtask

  task automatic test_extreme_values();
    send_op(MODE_SET, 1, 1, VALUE_TOP);
    send_op(MODE_SET, 1024, 1, VALUE_BOTTOM);
    send_op(MODE_ADD, 512, 2047, -16'sd1);
    send_op(MODE_ADD, 512, 0, -16'sd1);
    send_op(MODE_SUM, 1, 1024, '0);
    send_op(MODE_MAX, 1, 1024, '0);
    send_op(MODE_MAX, 1024, 1024, '0);
    send_op(MODE_MAX, 512, 1023, '0);
    send_op(MODE_SUM, 1, 1, '0);
  endtask

  task automatic test_ignored_updates();
    send_op(MODE_ADD, 0, 5, VALUE_TOP);
    send_op(MODE_ADD, 1025, 5, VALUE_TOP);
    send_op(MODE_SET, 2047, 2047, -16'sd1);
    send_op(MODE_SUM, 1, 1024, '0);
  endtask

  task automatic test_bad_bounds();
    send_op(MODE_SUM, 0, 5, '0);
    send_op(MODE_MAX, 6, 5, '0);
    send_op(MODE_SUM, 1, 1025, '0);
    send_op(MODE_MAX, 2047, 2047, '0);
  endtask

  // size 0 acts as 1; a leaf pushed well below -40000 must still be the maximum
  task automatic test_size_clamp_and_clear();
    write_size(0);
    send_op(MODE_SET, 1, 1, VALUE_BOTTOM);
    send_op(MODE_ADD, 1, 1, VALUE_BOTTOM);
    send_op(MODE_MAX, 1, 1, '0);
    send_op(MODE_SUM, 1, 1, '0);
    send_op(MODE_SUM, 1, 2, '0);
    write_size(2047);
    send_op(MODE_SUM, 1, 1024, '0);
  endtask

  task automatic test_random_sizes();
    run_random(300);
    write_size(2);
    run_random(100);
    write_size(1);
    run_random(60);
    write_size(1023);
    run_random(200);
    write_size(5);
    run_random(150);
  endtask

  task automatic test_steady_stream();
    write_size(pos_t'($urandom_range(1022, 3)));
    steady = 1'b1;
    run_random(250);
    steady = 1'b0;
  endtask

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : check_answers
    query_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected transaction: answer %0d, bad_range %0b", out_answer, out_bad_range);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_answer !== want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, out_answer);
          errors++;
        end
        if (out_bad_range !== want.bad_range) begin
          $error("bad_range: expected %0b, got %0b", want.bad_range, out_bad_range);
          errors++;
        end
        answers_checked++;
      end
    end
  end

  initial begin
    clear_tree();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_extreme_values();
    test_ignored_updates();
    test_bad_bounds();
    test_size_clamp_and_clear();
    test_random_sizes();
    test_steady_stream();
    wait_quiet();
    $display("Ran %0d operations across %0d size writes; %0d answers compared.",
             ops_sent, size_writes, answers_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
